// ===== src/asmi_pkg.sv =====
// Shared types and constants of the axis segment map interpolator.
// Holds the payload structs, command and register codes, and the microcode word format.
`default_nettype none

package asmi_pkg;

  // Command codes of an input transfer.
  localparam logic [1:0] CMD_LOAD_AXIS = 2'd0;
  localparam logic [1:0] CMD_LOAD_PAIR = 2'd1;
  localparam logic [1:0] CMD_MAP       = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_TOTAL = 2'd1;
  localparam int unsigned CFG_DATA_W = 9;

  // Input item.
  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         axis;
    logic [7:0]         entry_index;
    logic [8:0]         pair_count;
    logic signed [15:0] from_value;
    logic signed [15:0] to_value;
    logic signed [15:0] map_input;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic signed [15:0] mapped_value;
    logic               passed_through;
  } out_item_t;

  // Map request captured when a map command is accepted.
  typedef struct packed {
    logic               axis_ok;
    logic [7:0]         base;
    logic [8:0]         count;
    logic signed [15:0] value;
  } req_t;

  // Datapath operations.
  localparam logic [3:0] OP_NOP         = 4'd0;
  localparam logic [3:0] OP_SETUP       = 4'd1;
  localparam logic [3:0] OP_LOAD_PREV   = 4'd2;
  localparam logic [3:0] OP_LOAD_CUR    = 4'd3;
  localparam logic [3:0] OP_ADVANCE     = 4'd4;
  localparam logic [3:0] OP_DIFF        = 4'd5;
  localparam logic [3:0] OP_MUL         = 4'd6;
  localparam logic [3:0] OP_DIV_INIT    = 4'd7;
  localparam logic [3:0] OP_DIV_STEP    = 4'd8;
  localparam logic [3:0] OP_EMIT_INTERP = 4'd9;
  localparam logic [3:0] OP_EMIT_PREV   = 4'd10;
  localparam logic [3:0] OP_EMIT_CUR    = 4'd11;
  localparam logic [3:0] OP_EMIT_PASS   = 4'd12;

  // Table read address selection.
  localparam logic [1:0] A_NONE = 2'd0;
  localparam logic [1:0] A_BASE = 2'd1;
  localparam logic [1:0] A_LAST = 2'd2;
  localparam logic [1:0] A_NEXT = 2'd3;

  // Jump conditions.
  localparam logic [3:0] C_NONE     = 4'd0;
  localparam logic [3:0] C_ALWAYS   = 4'd1;
  localparam logic [3:0] C_PASS     = 4'd2;
  localparam logic [3:0] C_SINGLE   = 4'd3;
  localparam logic [3:0] C_LE_FIRST = 4'd4;
  localparam logic [3:0] C_GE_LAST  = 4'd5;
  localparam logic [3:0] C_BRACKET  = 4'd6;
  localparam logic [3:0] C_NOT_END  = 4'd7;
  localparam logic [3:0] C_ZERO_W   = 4'd8;
  localparam logic [3:0] C_DIV_MORE = 4'd9;

  localparam int unsigned PC_W = 4;

  // Restoring divider produces one quotient bit per step.
  localparam int unsigned DIV_STEPS = 16;
  localparam logic [3:0]  DIV_LAST  = 4'(DIV_STEPS - 1);

  // One microcode word.
  typedef struct packed {
    logic [3:0]      op;
    logic [1:0]      asel;
    logic [3:0]      cond;
    logic [PC_W-1:0] target;
    logic            done;
  } ctrl_t;

  localparam ctrl_t CTRL_IDLE = '{op: OP_NOP, asel: A_NONE, cond: C_NONE,
                                  target: '0, done: 1'b0};

  // Status flags from the datapath that steer the jumps.
  typedef struct packed {
    logic pass;
    logic single;
    logic le_first;
    logic ge_last;
    logic bracket;
    logic not_end;
    logic zero_w;
    logic div_more;
  } cond_t;

endpackage

`default_nettype wire

// ===== src/axis_segment_map_interpolator_unit.sv =====
// Map command: the program sets up the bounds and then either passes the value through, gives
// an end output for a single pair or for a value at or beyond an end, or scans the pairs in
// order; a zero-width pair gives its right end, any other bracketing pair is interpolated by a
// multiply and the 16-step divider, and a value that no pair brackets passes through.
// Loads take effect at accept and give no result; the next command is taken with the result.
// Reset clears configuration, axis bases and counts; the table is undefined until written.
`default_nettype none

module axis_segment_map_interpolator_unit import asmi_pkg::*; #(
  parameter int AXES          = 16,
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int XW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int AW = $clog2(TABLE_ENTRIES);

  logic [4:0]    axis_count_r;
  logic [8:0]    seg_total_r;
  logic [8:0]    pair_cnt_r [AXES];
  logic [7:0]    base_r     [AXES];
  req_t          req_r;
  logic          accept, map_go, axis_in_range, entry_in_range, tbl_we;
  logic [XW-1:0] ax_idx;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  ctrl_t         cw;
  cond_t         cond;

  // Configuration writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_count_r <= '0;
      seg_total_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AXIS_COUNT:    axis_count_r <= cfg_data[4:0];
        CFG_SEGMENT_TOTAL: seg_total_r  <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  // Command decode.
  assign accept         = start && !busy;
  assign axis_in_range  = (32'(in_data.axis) < 32'(AXES));
  assign entry_in_range = (32'(in_data.entry_index) < 32'(TABLE_ENTRIES));
  assign ax_idx         = XW'(in_data.axis);
  assign map_go         = accept && (in_data.command == CMD_MAP);
  assign tbl_we         = accept && (in_data.command == CMD_LOAD_PAIR) && entry_in_range;

  // Per-axis base and pair count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        pair_cnt_r[i] <= '0;
        base_r[i]     <= '0;
      end
    end else if (accept && (in_data.command == CMD_LOAD_AXIS) && axis_in_range) begin
      pair_cnt_r[ax_idx] <= in_data.pair_count;
      base_r[ax_idx]     <= in_data.entry_index;
    end
  end

  // Capture the map request for the program.
  always_ff @(posedge clk) begin
    if (map_go) begin
      req_r.axis_ok <= axis_in_range && ({1'b0, in_data.axis} < axis_count_r);
      req_r.base    <= base_r[ax_idx];
      req_r.count   <= pair_cnt_r[ax_idx];
      req_r.value   <= in_data.map_input;
    end
  end

  // Shared from/to table.
  asmi_ram #(
    .WIDTH(32),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(AW'(in_data.entry_index)),
    .wdata({in_data.from_value, in_data.to_value}),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  asmi_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (map_go),
    .cond (cond),
    .cw   (cw),
    .busy (busy)
  );

  asmi_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cw       (cw),
    .req      (req_r),
    .seg_total(seg_total_r),
    .ram_rdata(ram_rdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .cond     (cond),
    .out_valid(out_valid),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // The program ends only on a step that shows a result.
  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("program ended without a result");

  // A result is only produced by a running program.
  a_out_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result strobe without a running program");

  // An accepted map command starts the program.
  a_map_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.command == CMD_MAP)) |=> busy)
    else $error("map transfer did not start the program");

  // Load and unused commands give no result.
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.command != CMD_MAP)) |=> !out_valid)
    else $error("result strobe after a load transfer");
`endif

endmodule

`default_nettype wire

// ===== src/asmi_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module asmi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/asmi_seq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on asmi_pkg for the control word and condition formats.
`default_nettype none

module asmi_seq import asmi_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  go,
  input  wire cond_t cond,
  output ctrl_t      cw,
  output logic       busy
);

  // Step labels.
  localparam logic [PC_W-1:0] S_SETUP     = 4'd0;
  localparam logic [PC_W-1:0] S_FIRST     = 4'd1;
  localparam logic [PC_W-1:0] S_LASTE     = 4'd2;
  localparam logic [PC_W-1:0] S_CHK_LAST  = 4'd3;
  localparam logic [PC_W-1:0] S_SRCH_RD   = 4'd4;
  localparam logic [PC_W-1:0] S_SRCH_CMP  = 4'd5;
  localparam logic [PC_W-1:0] S_SRCH_NXT  = 4'd6;
  localparam logic [PC_W-1:0] S_NO_HIT    = 4'd7;
  localparam logic [PC_W-1:0] S_DIFF      = 4'd8;
  localparam logic [PC_W-1:0] S_MUL       = 4'd9;
  localparam logic [PC_W-1:0] S_DIV_INIT  = 4'd10;
  localparam logic [PC_W-1:0] S_DIV_STEP  = 4'd11;
  localparam logic [PC_W-1:0] S_OUT_INTP  = 4'd12;
  localparam logic [PC_W-1:0] S_OUT_PREV  = 4'd13;
  localparam logic [PC_W-1:0] S_OUT_CUR   = 4'd14;
  localparam logic [PC_W-1:0] S_OUT_PASS  = 4'd15;

  // Control store of the map program.
  function automatic ctrl_t rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = CTRL_IDLE;
    case (pc)
      S_SETUP:    w = '{op: OP_SETUP, asel: A_BASE, cond: C_PASS,
                        target: S_OUT_PASS, done: 1'b0};
      S_FIRST:    w = '{op: OP_LOAD_PREV, asel: A_LAST, cond: C_SINGLE,
                        target: S_OUT_PREV, done: 1'b0};
      S_LASTE:    w = '{op: OP_LOAD_CUR, asel: A_NONE, cond: C_LE_FIRST,
                        target: S_OUT_PREV, done: 1'b0};
      S_CHK_LAST: w = '{op: OP_NOP, asel: A_NONE, cond: C_GE_LAST,
                        target: S_OUT_CUR, done: 1'b0};
      S_SRCH_RD:  w = '{op: OP_NOP, asel: A_NEXT, cond: C_NONE,
                        target: '0, done: 1'b0};
      S_SRCH_CMP: w = '{op: OP_LOAD_CUR, asel: A_NONE, cond: C_BRACKET,
                        target: S_DIFF, done: 1'b0};
      S_SRCH_NXT: w = '{op: OP_ADVANCE, asel: A_NONE, cond: C_NOT_END,
                        target: S_SRCH_RD, done: 1'b0};
      S_NO_HIT:   w = '{op: OP_NOP, asel: A_NONE, cond: C_ALWAYS,
                        target: S_OUT_PASS, done: 1'b0};
      S_DIFF:     w = '{op: OP_DIFF, asel: A_NONE, cond: C_ZERO_W,
                        target: S_OUT_CUR, done: 1'b0};
      S_MUL:      w = '{op: OP_MUL, asel: A_NONE, cond: C_NONE,
                        target: '0, done: 1'b0};
      S_DIV_INIT: w = '{op: OP_DIV_INIT, asel: A_NONE, cond: C_NONE,
                        target: '0, done: 1'b0};
      S_DIV_STEP: w = '{op: OP_DIV_STEP, asel: A_NONE, cond: C_DIV_MORE,
                        target: S_DIV_STEP, done: 1'b0};
      S_OUT_INTP: w = '{op: OP_EMIT_INTERP, asel: A_NONE, cond: C_NONE,
                        target: '0, done: 1'b1};
      S_OUT_PREV: w = '{op: OP_EMIT_PREV, asel: A_NONE, cond: C_NONE,
                        target: '0, done: 1'b1};
      S_OUT_CUR:  w = '{op: OP_EMIT_CUR, asel: A_NONE, cond: C_NONE,
                        target: '0, done: 1'b1};
      S_OUT_PASS: w = '{op: OP_EMIT_PASS, asel: A_NONE, cond: C_NONE,
                        target: '0, done: 1'b1};
      default:    w = CTRL_IDLE;
    endcase
    return w;
  endfunction

  logic            running_r;
  logic [PC_W-1:0] pc_r;
  logic            take;

  assign cw   = running_r ? rom(pc_r) : CTRL_IDLE;
  assign busy = running_r;

  // Jump condition selection.
  always_comb begin
    case (cw.cond)
      C_NONE:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_PASS:     take = cond.pass;
      C_SINGLE:   take = cond.single;
      C_LE_FIRST: take = cond.le_first;
      C_GE_LAST:  take = cond.ge_last;
      C_BRACKET:  take = cond.bracket;
      C_NOT_END:  take = cond.not_end;
      C_ZERO_W:   take = cond.zero_w;
      C_DIV_MORE: take = cond.div_more;
      default:    take = 1'b0;
    endcase
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      pc_r      <= '0;
    end else if (go) begin
      running_r <= 1'b1;
      pc_r      <= S_SETUP;
    end else if (running_r) begin
      if (cw.done) begin
        running_r <= 1'b0;
      end else if (take) begin
        pc_r <= cw.target;
      end else begin
        pc_r <= pc_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/asmi_dp.sv =====
// Datapath of the map program: bounds setup, segment search, multiply and divide.
// Depends on asmi_pkg; reads the shared table through the RAM port in the top level.
`default_nettype none

module asmi_dp import asmi_pkg::*; #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire ctrl_t                            cw,
  input  wire req_t                             req,
  input  wire logic [8:0]                       seg_total,
  input  wire logic [31:0]                      ram_rdata,
  output logic                                  ram_re,
  output logic      [$clog2(TABLE_ENTRIES)-1:0] ram_raddr,
  output cond_t                                 cond,
  output logic                                  out_valid,
  output out_item_t                             out_data
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int LW = $clog2(TABLE_ENTRIES + 1);
  localparam int NW = ((LW > 9) ? LW : 9) + 1;
  localparam logic [NW-1:0] TE = NW'(TABLE_ENTRIES);

  logic signed [15:0] ram_from, ram_to;
  logic [NW-1:0]      base_w, cnt_w, tot_w, limit_w, avail_w, eff_w, last_w;
  logic               pass_w;
  logic [AW-1:0]      last_r, idx_r, next_idx;
  logic               single_r;
  logic signed [15:0] prev_from_r, prev_to_r, cur_from_r, cur_to_r;
  logic [15:0]        dx_r, den_r, dmag_r;
  logic               neg_r;
  logic [31:0]        prod_r, prod_w;
  logic [15:0]        rem_r, quo_r, rem_nxt;
  logic [3:0]         div_cnt_r;
  logic [16:0]        dx_u, den_u, dy_u, dmag_u, div_t, div_d, q_u, res_u;
  logic               div_ge, emit_w;
  logic               out_valid_r;
  out_item_t          out_data_r;

  assign ram_from = ram_rdata[31:16];
  assign ram_to   = ram_rdata[15:0];

  // Usable table size, clipped pair count and the last pair of the axis.
  assign base_w  = NW'(req.base);
  assign cnt_w   = NW'(req.count);
  assign tot_w   = NW'(seg_total);
  assign limit_w = (tot_w > TE) ? TE : tot_w;
  assign avail_w = limit_w - base_w;
  assign eff_w   = (cnt_w < avail_w) ? cnt_w : avail_w;
  assign last_w  = base_w + eff_w - 1'b1;
  assign pass_w  = !req.axis_ok || (req.count == 9'd0) || (base_w >= limit_w);

  assign next_idx = idx_r + 1'b1;

  // Table read address.
  always_comb begin
    case (cw.asel)
      A_BASE:  ram_raddr = base_w[AW-1:0];
      A_LAST:  ram_raddr = last_r;
      A_NEXT:  ram_raddr = next_idx;
      default: ram_raddr = idx_r;
    endcase
  end
  assign ram_re = (cw.asel != A_NONE);

  // Segment differences; the value lies inside the segment, so dx and den are nonnegative.
  assign dx_u   = {req.value[15], req.value} - {prev_from_r[15], prev_from_r};
  assign den_u  = {cur_from_r[15], cur_from_r} - {prev_from_r[15], prev_from_r};
  assign dy_u   = {cur_to_r[15], cur_to_r} - {prev_to_r[15], prev_to_r};
  assign dmag_u = dy_u[16] ? (17'd0 - dy_u) : dy_u;

  assign prod_w = dx_r * dmag_r;

  // One restoring division step.
  assign div_t   = {rem_r, quo_r[15]};
  assign div_d   = {1'b0, den_r};
  assign div_ge  = (div_t >= div_d);
  assign rem_nxt = div_ge ? 16'(div_t - div_d) : div_t[15:0];

  // Signed quotient added to the left output.
  assign q_u   = neg_r ? (17'd0 - {1'b0, quo_r}) : {1'b0, quo_r};
  assign res_u = {prev_to_r[15], prev_to_r} + q_u;

  // Flags for the sequencer.
  assign cond.pass     = pass_w;
  assign cond.single   = single_r;
  assign cond.le_first = (req.value <= prev_from_r);
  assign cond.ge_last  = (req.value >= cur_from_r);
  assign cond.bracket  = (req.value >= prev_from_r) && (req.value <= ram_from);
  assign cond.not_end  = (next_idx != last_r);
  assign cond.zero_w   = (cur_from_r == prev_from_r);
  assign cond.div_more = (div_cnt_r != DIV_LAST);

  // Datapath registers under control of the current word.
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_SETUP: begin
        last_r   <= last_w[AW-1:0];
        idx_r    <= base_w[AW-1:0];
        single_r <= (eff_w == NW'(1));
      end
      OP_LOAD_PREV: begin
        prev_from_r <= ram_from;
        prev_to_r   <= ram_to;
      end
      OP_LOAD_CUR: begin
        cur_from_r <= ram_from;
        cur_to_r   <= ram_to;
      end
      OP_ADVANCE: begin
        prev_from_r <= cur_from_r;
        prev_to_r   <= cur_to_r;
        idx_r       <= next_idx;
      end
      OP_DIFF: begin
        dx_r   <= dx_u[15:0];
        den_r  <= den_u[15:0];
        dmag_r <= dmag_u[15:0];
        neg_r  <= dy_u[16];
      end
      OP_MUL: begin
        prod_r <= prod_w;
      end
      OP_DIV_INIT: begin
        rem_r     <= prod_r[31:16];
        quo_r     <= prod_r[15:0];
        div_cnt_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r     <= rem_nxt;
        quo_r     <= {quo_r[14:0], div_ge};
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      OP_EMIT_INTERP: begin
        out_data_r <= '{mapped_value: res_u[15:0], passed_through: 1'b0};
      end
      OP_EMIT_PREV: begin
        out_data_r <= '{mapped_value: prev_to_r, passed_through: 1'b0};
      end
      OP_EMIT_CUR: begin
        out_data_r <= '{mapped_value: cur_to_r, passed_through: 1'b0};
      end
      OP_EMIT_PASS: begin
        out_data_r <= '{mapped_value: req.value, passed_through: 1'b1};
      end
      default: begin
      end
    endcase
  end

  // Result strobe.
  assign emit_w = (cw.op == OP_EMIT_INTERP) || (cw.op == OP_EMIT_PREV) ||
                  (cw.op == OP_EMIT_CUR) || (cw.op == OP_EMIT_PASS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== test/axis_segment_map_interpolator_unit_tb.sv =====
// Self-checking testbench for axis_segment_map_interpolator_unit: loads axis ranges and table
// pairs, remaps coordinates and checks every result against an in-bench predictor.
// Depends only on asmi_pkg and the unit itself.
`timescale 1ns / 100ps

module axis_segment_map_interpolator_unit_tb;
  import asmi_pkg::*;

  localparam int AXES_N        = 16;
  localparam int TABLE_N       = 256;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_data = '0;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state, updated at each accepted transfer.
  logic [4:0]         axes_enabled = '0;
  logic [8:0]         table_total = '0;
  logic [7:0]         map_base [AXES_N];
  logic [8:0]         map_count [AXES_N];
  logic signed [15:0] pair_from [TABLE_N];
  logic signed [15:0] pair_to [TABLE_N];
  out_item_t          expected_results [$];

  // Stimulus planning state, which runs ahead of the transfers.
  in_item_t   pending_cmds [$];
  logic [7:0] plan_base [AXES_N];
  logic [8:0] plan_count [AXES_N];
  bit         pair_written [TABLE_N];
  int         queued_items = 0;
  bit         steady = 1'b0;

  int mismatches = 0;
  int cycle_count = 0;
  int n_axis_loads = 0;
  int n_pair_loads = 0;
  int n_maps = 0;
  int n_ignored = 0;
  int n_results = 0;
  int n_passed = 0;
  int n_reg_writes = 0;

  axis_segment_map_interpolator_unit #(
    .AXES          (AXES_N),
    .TABLE_ENTRIES (TABLE_N)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Piecewise-linear remap of one coordinate through the axis's pairs.
  function automatic out_item_t remap_coord(logic [3:0] ax, logic signed [15:0] v);
    out_item_t r;
    int        lim, cnt, b, last, i;
    longint    q;
    r.mapped_value   = v;
    r.passed_through = 1'b1;
    if (ax >= axes_enabled) return r;
    cnt = map_count[ax];
    if (cnt == 0) return r;
    b   = map_base[ax];
    lim = (table_total < TABLE_N) ? table_total : TABLE_N;
    if (b >= lim) return r;
    if (cnt > lim - b) cnt = lim - b;
    r.passed_through = 1'b0;
    last = b + cnt - 1;
    // A single pair, or a value at or beyond an end, takes an end output.
    if (cnt == 1 || v <= pair_from[b]) begin
      r.mapped_value = pair_to[b];
      return r;
    end
    if (v >= pair_from[last]) begin
      r.mapped_value = pair_to[last];
      return r;
    end
    // The first segment that brackets the value decides; a zero-width one gives its right end.
    for (i = b; i < last; i++) begin
      if (v >= pair_from[i] && v <= pair_from[i+1]) begin
        if (pair_from[i] == pair_from[i+1]) begin
          r.mapped_value = pair_to[i+1];
        end else begin
          q = (longint'(v) - pair_from[i]) * (longint'(pair_to[i+1]) - pair_to[i]) /
              (longint'(pair_from[i+1]) - pair_from[i]);
          r.mapped_value = 16'(longint'(pair_to[i]) + q);
        end
        return r;
      end
    end
    r.mapped_value   = v;
    r.passed_through = 1'b1;
    return r;
  endfunction

  // Apply one accepted transfer to the predictor state.
  function automatic void apply_command(in_item_t it);
    case (it.command)
      CMD_LOAD_AXIS: begin
        map_base[it.axis]  = it.entry_index;
        map_count[it.axis] = it.pair_count;
        n_axis_loads++;
      end
      CMD_LOAD_PAIR: begin
        pair_from[it.entry_index] = it.from_value;
        pair_to[it.entry_index]   = it.to_value;
        n_pair_loads++;
      end
      CMD_MAP: begin
        expected_results.push_back(remap_coord(it.axis, it.map_input));
        n_maps++;
      end
      default: begin
        n_ignored++;
      end
    endcase
  endfunction

  // Item with random content in every field; callers overwrite what matters.
  function automatic in_item_t random_item();
    in_item_t    it;
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    it = noise[$bits(in_item_t)-1:0];
    it.pair_count = 9'($urandom_range(0, 256));
    return it;
  endfunction

  function automatic void enqueue(in_item_t it);
    pending_cmds.push_back(it);
    if (it.command != CMD_UNUSED) queued_items++;
  endfunction

  function automatic void queue_pair(logic [7:0] idx, logic signed [15:0] f,
                                     logic signed [15:0] t);
    in_item_t it;
    it = random_item();
    it.command     = CMD_LOAD_PAIR;
    it.entry_index = idx;
    it.from_value  = f;
    it.to_value    = t;
    pair_written[idx] = 1'b1;
    enqueue(it);
  endfunction

  function automatic void queue_axis(logic [3:0] ax, logic [7:0] b, logic [8:0] cnt);
    in_item_t it;
    it = random_item();
    it.command     = CMD_LOAD_AXIS;
    it.axis        = ax;
    it.entry_index = b;
    it.pair_count  = cnt;
    plan_base[ax]  = b;
    plan_count[ax] = cnt;
    enqueue(it);
  endfunction

  // A map never reads a table entry that was not written: missing ones get loaded first.
  function automatic void queue_map(logic [3:0] ax, logic signed [15:0] v);
    in_item_t it;
    int       lim, cnt, b, e;
    if (ax < axes_enabled && plan_count[ax] != 0) begin
      lim = (table_total < TABLE_N) ? table_total : TABLE_N;
      b   = plan_base[ax];
      cnt = plan_count[ax];
      if (b < lim) begin
        if (cnt > lim - b) cnt = lim - b;
        for (e = b; e < b + cnt; e++) begin
          if (!pair_written[e]) queue_pair(8'(e), 16'($urandom), 16'($urandom));
        end
      end
    end
    it = random_item();
    it.command   = CMD_MAP;
    it.axis      = ax;
    it.map_input = v;
    enqueue(it);
  endfunction

  function automatic void queue_unused();
    in_item_t it;
    it = random_item();
    it.command = CMD_UNUSED;
    enqueue(it);
  endfunction

  // Well-formed axis: ascending from values (some repeated), then maps aimed at the pairs.
  function automatic void queue_ramp(logic [3:0] ax, int b, int cnt);
    int from_list [$];
    int cur, span, k, left, f, pick;
    cur = ($urandom_range(0, 3) == 0) ? -32768 : int'($urandom_range(0, 49152)) - 32768;
    for (k = 0; k < cnt; k++) begin
      left = cnt - 1 - k;
      if (left == 0 && $urandom_range(0, 3) == 0) cur = 32767;
      from_list.push_back(cur);
      queue_pair(8'(b + k), 16'(cur), 16'($urandom));
      if (left > 0) begin
        span = (32767 - cur) / left;
        if (span > 0 && $urandom_range(0, 9) != 0) cur += $urandom_range(1, span);
      end
    end
    queue_axis(ax, 8'(b), 9'(cnt));
    repeat ($urandom_range(2, 6)) begin
      k    = $urandom_range(0, cnt - 1);
      pick = $urandom_range(0, 6);
      case (pick)
        0: f = from_list[k];
        1: f = from_list[k] + 1;
        2: f = from_list[k] - 1;
        3: f = (k + 1 < cnt) ? (from_list[k] + from_list[k+1]) / 2 : from_list[k];
        4: f = -32768;
        5: f = 32767;
        default: f = int'($urandom_range(0, 65535)) - 32768;
      endcase
      queue_map(ax, 16'(f));
    end
  endfunction

  // Mostly well-formed axes with random content, the rest stray loads and maps.
  function automatic void queue_random(int n);
    int         goal, pick, r, cnt, lim, b;
    logic [3:0] ax;
    goal = queued_items + n;
    while (queued_items < goal) begin
      pick = $urandom_range(0, 99);
      ax = (axes_enabled > 0 && $urandom_range(0, 9) != 0) ?
           4'($urandom_range(0, axes_enabled - 1)) : 4'($urandom_range(0, 15));
      if (pick < 55) begin
        r   = $urandom_range(0, 99);
        cnt = (r < 70) ? $urandom_range(1, 6) :
              (r < 96) ? $urandom_range(7, 24) : $urandom_range(25, 64);
        lim = (table_total < TABLE_N) ? table_total : TABLE_N;
        b = (lim >= cnt && $urandom_range(0, 7) != 0) ? $urandom_range(0, lim - cnt) :
            $urandom_range(0, TABLE_N - cnt);
        queue_ramp(ax, b, cnt);
      end else if (pick < 68) begin
        queue_pair(8'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 78) begin
        cnt = ($urandom_range(0, 9) == 0) ? 256 : $urandom_range(0, 8);
        queue_axis(ax, 8'($urandom), 9'(cnt));
      end else if (pick < 96) begin
        queue_map(ax, 16'($urandom));
      end else begin
        queue_unused();
      end
    end
  endfunction

  // Write one register over the configuration channel and mirror it in the predictor.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_AXIS_COUNT:    axes_enabled = value[4:0];
      CFG_SEGMENT_TOTAL: table_total  = value[8:0];
      default: ;
    endcase
    n_reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued transfer went through and every result came back.
  // Sampled mid-cycle, so the driver's updates at the edge are already settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic next_phase(input int unsigned ax_cnt, input int unsigned total);
    wait_idle();
    write_reg(CFG_AXIS_COUNT, ax_cnt);
    write_reg(CFG_SEGMENT_TOTAL, total);
  endtask

  // Driver: presents queued commands, holding each one until a transfer takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) apply_command(in_data);
      if (!(start && busy)) begin
        if (pending_cmds.size() > 0 && (steady || $urandom_range(0, 99) >= 34)) begin
          start   <= 1'b1;
          in_data <= pending_cmds.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result strobe is checked against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (out_data.passed_through) n_passed++;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: mapped_value %0d passed_through %0b",
                 $time, out_data.mapped_value, out_data.passed_through);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.mapped_value !== want.mapped_value) begin
          $display("%0t: mapped_value expected %0d actual %0d",
                   $time, want.mapped_value, out_data.mapped_value);
          mismatches++;
        end
        if (out_data.passed_through !== want.passed_through) begin
          $display("%0t: passed_through expected %0b actual %0b",
                   $time, want.passed_through, out_data.passed_through);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d results still expected",
               $time, cycle_count, expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int a = 0; a < AXES_N; a++) begin
      map_base[a]   = '0;
      map_count[a]  = '0;
      plan_base[a]  = '0;
      plan_count[a] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset state: no axis is enabled, so maps pass through.
    queue_map(4'd0, 16'sd32767);
    queue_map(4'd9, -16'sd32768);

    // Full table with an axis spanning both extremes of the coordinate.
    next_phase(16, 256);
    queue_pair(8'd0, -16'sd32768, 16'sd32767);
    queue_pair(8'd1, 16'sd0, -16'sd32768);
    queue_pair(8'd2, 16'sd0, 16'sd5);
    queue_pair(8'd3, 16'sd32767, 16'sd32767);
    queue_axis(4'd0, 8'd0, 9'd4);
    queue_map(4'd0, -16'sd32768);
    queue_map(4'd0, 16'sd32767);
    queue_map(4'd0, -16'sd1);
    queue_map(4'd0, 16'sd0);
    queue_map(4'd0, 16'sd16384);
    // Last entry with the widest count: cut short to a single pair.
    queue_pair(8'd255, 16'sd1234, -16'sd4321);
    queue_axis(4'd15, 8'd255, 9'd256);
    queue_map(4'd15, 16'sd21845);
    queue_map(4'd15, -16'sd21846);
    // An axis without pairs passes through.
    queue_axis(4'd1, 8'd0, 9'd0);
    queue_map(4'd1, 16'sd100);
    queue_unused();

    // Few axes and a short table: disabled axis, base past the table, clipped axis.
    next_phase(3, 10);
    queue_map(4'd15, 16'sd7);
    queue_axis(4'd2, 8'd200, 9'd3);
    queue_map(4'd2, 16'sd7);
    queue_axis(4'd1, 8'd8, 9'd5);
    queue_map(4'd1, 16'sd0);
    queue_map(4'd1, -16'sd32768);
    queue_map(4'd0, -16'sd8192);

    next_phase(16, 256);
    queue_random(100);

    // Back-to-back transfers, including one axis that covers the whole table.
    next_phase(16, 256);
    steady = 1'b1;
    queue_ramp(4'd0, 0, 256);
    queue_random(150);
    next_phase(5, 64);
    steady = 1'b0;
    queue_random(150);

    next_phase(1, 1);
    queue_random(60);
    next_phase(16, 0);
    queue_random(40);
    next_phase(0, 256);
    queue_random(40);
    next_phase($urandom_range(1, 16), $urandom_range(0, 256));
    queue_random(150);
    next_phase(16, 256);
    queue_random(100);
    wait_idle();

    $display("Covered %0d axis loads, %0d pair loads, %0d maps and %0d unused commands",
             n_axis_loads, n_pair_loads, n_maps, n_ignored);
    $display("over %0d register writes; %0d results checked, %0d of them passed through.",
             n_reg_writes, n_results, n_passed);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== axis_segment_map_interpolator_unit.f =====
src/asmi_pkg.sv
src/asmi_ram.sv
src/asmi_seq.sv
src/asmi_dp.sv
src/axis_segment_map_interpolator_unit.sv
test/axis_segment_map_interpolator_unit_tb.sv
